// ===== src/xfc_pkg.sv =====
// Shared types and constants for the XOR frame checker.
// Depends on nothing; every other file in src imports it.
package xfc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CIDX_W  = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CIDX_W-1:0] t_cfg_idx;

    // Frame geometry
    localparam t_pos POS_START_ONE = 16'd0;
    localparam t_pos POS_START_TWO = 16'd1;
    localparam t_pos POS_COMMAND   = 16'd2;
    localparam t_pos POS_LENGTH    = 16'd3;
    localparam logic [POS_W:0] HEADER_LEN = 17'd4;
    localparam logic [POS_W:0] MIN_FRAME  = 17'd7;
    localparam t_pos POS_MAX = {POS_W{1'b1}};

    // Verdict codes
    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_SHORT     = 3'd1;
    localparam t_status STAT_BAD_START = 3'd2;
    localparam t_status STAT_TRUNC     = 3'd3;
    localparam t_status STAT_BAD_END   = 3'd4;
    localparam t_status STAT_BAD_CKSUM = 3'd5;

    // Configuration register indexes
    localparam t_cfg_idx CFG_START_ONE = 8'd0;
    localparam t_cfg_idx CFG_START_TWO = 8'd1;
    localparam t_cfg_idx CFG_END_ONE   = 8'd2;
    localparam t_cfg_idx CFG_END_TWO   = 8'd3;

    // Configuration reset values
    localparam t_byte RST_START_ONE = 8'd170;
    localparam t_byte RST_START_TWO = 8'd85;
    localparam t_byte RST_END_ONE   = 8'd13;
    localparam t_byte RST_END_TWO   = 8'd10;

    typedef struct packed {
        t_byte start_one;
        t_byte start_two;
        t_byte end_one;
        t_byte end_two;
    } t_cfg;

    typedef struct packed {
        logic    payload_valid;
        t_byte   payload_byte;
        logic    frame_done;
        t_status status;
        t_byte   command;
        t_byte   payload_length;
    } t_result;

endpackage

// ===== src/xfc_frame_track.sv =====
// Per-byte frame tracker: position, header capture, running XOR, verdict.
// Depends on xfc_pkg.
module xfc_frame_track (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xfc_pkg::t_cfg  i_cfg,
    input  logic           i_fire,
    input  xfc_pkg::t_byte i_rx_byte,
    input  logic           i_frame_end,
    output xfc_pkg::t_result o_result
);
    import xfc_pkg::*;

    t_pos  r_pos,   n_pos;
    t_byte r_xor,   n_xor;
    t_byte r_cmd,   n_cmd;
    t_byte r_len,   n_len;
    logic  r_start, n_start;
    logic  r_cks,   n_cks;
    t_byte r_prev,  n_prev;

    logic [POS_W:0] pos_x;
    logic [POS_W:0] pay_end;
    logic [POS_W:0] total;
    logic           in_body;
    logic           pay;
    t_status        status;

    always_comb begin
        pos_x   = {1'b0, r_pos};
        pay_end = {{(POS_W+1-BYTE_W){1'b0}}, r_len} + HEADER_LEN;
        in_body = (r_pos > POS_LENGTH);
        pay     = in_body && (pos_x < pay_end);

        n_start = r_start;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_xor   = r_xor;
        n_cks   = r_cks;
        if (r_pos == POS_START_ONE) begin
            n_start = (i_rx_byte == i_cfg.start_one);
        end else if (r_pos == POS_START_TWO) begin
            n_start = r_start && (i_rx_byte == i_cfg.start_two);
        end else if (r_pos == POS_COMMAND) begin
            n_cmd = i_rx_byte;
            n_xor = i_rx_byte;
        end else if (r_pos == POS_LENGTH) begin
            n_len = i_rx_byte;
            n_xor = r_xor ^ i_rx_byte;
        end else if (pay) begin
            n_xor = r_xor ^ i_rx_byte;
        end else if (pos_x == pay_end) begin
            n_cks = (r_xor == i_rx_byte);
        end

        // Verdict, checks in priority order
        total = pos_x + 17'd1;
        if (total < MIN_FRAME) begin
            status = STAT_SHORT;
        end else if (!n_start) begin
            status = STAT_BAD_START;
        end else if (total < ({{(POS_W+1-BYTE_W){1'b0}}, n_len} + MIN_FRAME)) begin
            status = STAT_TRUNC;
        end else if (r_prev != i_cfg.end_one || i_rx_byte != i_cfg.end_two) begin
            status = STAT_BAD_END;
        end else if (!n_cks) begin
            status = STAT_BAD_CKSUM;
        end else begin
            status = STAT_OK;
        end

        o_result.payload_valid  = pay;
        o_result.payload_byte   = pay ? i_rx_byte : '0;
        o_result.frame_done     = i_frame_end;
        o_result.status         = i_frame_end ? status : STAT_OK;
        o_result.command        = i_frame_end ? n_cmd : '0;
        o_result.payload_length = i_frame_end ? n_len : '0;

        if (i_frame_end) begin
            n_pos   = '0;
            n_xor   = '0;
            n_cmd   = '0;
            n_len   = '0;
            n_start = 1'b0;
            n_cks   = 1'b0;
            n_prev  = '0;
        end else begin
            n_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
            n_prev = i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_xor   <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_start <= 1'b0;
            r_cks   <= 1'b0;
            r_prev  <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_start <= n_start;
            r_cks   <= n_cks;
            r_prev  <= n_prev;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_frame_end |=> r_pos == '0 && r_xor == '0 && !r_start && !r_cks)
        else $error("frame state not cleared after last beat");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_frame_end && r_pos != POS_MAX |=> r_pos == $past(r_pos) + 16'd1)
        else $error("byte position did not advance");
`endif

endmodule

// ===== src/xfc_out_skid.sv =====
// Result register with one skid entry; lets the tracker take a beat while
// a finished result waits. Depends on xfc_pkg.
module xfc_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  xfc_pkg::t_result i_in,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output xfc_pkg::t_result o_out,
    input  logic             i_out_stall
);
    import xfc_pkg::*;

    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    logic    in_fire, out_fire;

    assign o_in_stall  = r_sv;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign in_fire     = i_in_valid && !r_sv;
    assign out_fire    = r_ov && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_sv) begin
                // drain skid into output once it frees up
                if (out_fire) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end
            end else if (in_fire) begin
                if (r_ov && !out_fire) begin
                    r_sv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end else if (out_fire) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_ov && !out_fire) begin
                r_skid <= i_in;
            end else begin
                r_out <= i_in;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without a result in front");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && out_fire |=> r_ov && !r_sv && r_out == $past(r_skid))
        else $error("skid entry not moved to output");
`endif

endmodule

// ===== src/xor_frame_checker.sv =====
// Top level of the XOR frame checker: configuration registers, tracker and
// result stage. Depends on xfc_pkg, xfc_frame_track, xfc_out_skid.
//
// The checker takes a received frame one byte per beat, with i_frame_end set
// on the frame's last byte, and returns exactly one result beat per input beat.
// Frame layout: two start bytes, command, length L, L payload bytes, an XOR
// checksum over command, length and payload, then two end bytes; the end bytes
// are always the last two bytes of the buffer, so any filler between checksum
// and end bytes is ignored. Payload bytes (positions 4 .. 3+L) are passed out
// tentatively with o_payload_valid set; on the last byte o_frame_done is set
// and o_status gives the verdict, checked in this order: short (under 7 bytes),
// bad start, truncated, bad end bytes, bad checksum. o_command and
// o_payload_length carry the header bytes on the verdict beat (zero if the
// frame ended before them), and all frame state clears for the next frame.
// The byte counter saturates at 65535. Throughput is one byte per clock:
// the per-byte update is one compare and XOR between the tracker state and a
// result register. A single skid entry takes one more beat while the output
// side stalls; after that o_stall holds the sender until the waiting result
// moves on. Each result is registered in the result stage before o_valid.
// Configuration (index 0..3: start one, start two, end one, end two) is
// always ready; write it only while no frame is in flight.
module xor_frame_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  xfc_pkg::t_cfg_idx     i_cfg_index,
    input  xfc_pkg::t_byte        i_cfg_data,
    // input beats
    input  logic                  i_valid,
    output logic                  o_stall,
    input  xfc_pkg::t_byte        i_rx_byte,
    input  logic                  i_frame_end,
    // result beats
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_payload_valid,
    output xfc_pkg::t_byte        o_payload_byte,
    output logic                  o_frame_done,
    output xfc_pkg::t_status      o_status,
    output xfc_pkg::t_byte        o_command,
    output xfc_pkg::t_byte        o_payload_length
);
    import xfc_pkg::*;

    t_cfg    r_cfg;
    t_result trk_result;
    t_result out_result;
    logic    skid_stall;
    logic    in_fire;

    // Config writes are registered into r_cfg; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_one <= RST_START_ONE;
            r_cfg.start_two <= RST_START_TWO;
            r_cfg.end_one   <= RST_END_ONE;
            r_cfg.end_two   <= RST_END_TWO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_ONE: r_cfg.start_one <= i_cfg_data;
                CFG_START_TWO: r_cfg.start_two <= i_cfg_data;
                CFG_END_ONE:   r_cfg.end_one   <= i_cfg_data;
                CFG_END_TWO:   r_cfg.end_two   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a beat whenever the skid entry is free.
    assign o_stall = skid_stall;
    assign in_fire = i_valid && !skid_stall;

    xfc_frame_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fire      (in_fire),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_result    (trk_result)
    );

    xfc_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in        (trk_result),
        .o_in_stall  (skid_stall),
        .o_out_valid (o_valid),
        .o_out       (out_result),
        .i_out_stall (i_stall)
    );

    assign o_payload_valid  = out_result.payload_valid;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_frame_done     = out_result.frame_done;
    assign o_status         = out_result.status;
    assign o_command        = out_result.command;
    assign o_payload_length = out_result.payload_length;

`ifndef SYNTHESIS
    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |-> o_status == STAT_OK && o_command == '0
            && o_payload_length == '0)
        else $error("verdict fields set on a non-final beat");
`endif

endmodule
